// ===== design/kmsrf_pkg.sv =====
// Shared types, constants and codes of the k-mer set read filter.
package kmsrf_pkg;

	// Default sizes handed to the top level.
	localparam int TABLE_ENTRIES_DEF = 1024;
	localparam int MAX_K_DEF         = 31;
	localparam int POSITION_BITS_DEF = 16;

	// Fixed field widths.
	localparam int KMER_KEY_W  = 62;
	localparam int CFG_K_W     = 5;
	localparam int MATCH_POS_W = 16;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [CFG_K_W-1:0] KMER_LENGTH_RESET = 5'd31;

	// Register index of the configuration port.
	localparam logic [APB_ADDR_W-3:0] REG_KMER_LENGTH = 1'b0;

	// Command codes of an input beat.
	localparam logic CMD_INSERT    = 1'b0;
	localparam logic CMD_READ_BASE = 1'b1;

	// Kind codes of a result beat.
	localparam logic RES_INSERT = 1'b0;
	localparam logic RES_READ   = 1'b1;

	// Insert status codes.
	typedef enum logic [1:0] {
		INS_ADDED   = 2'd0,
		INS_PRESENT = 2'd1,
		INS_FULL    = 2'd2
	} ins_status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_WRITE_B,
		ST_INS_OUT,
		ST_READ_DONE
	} seq_state_t;

	// Commands from the sequencer to the key store.
	typedef struct packed {
		logic start;
		logic wr_a;
		logic wr_b;
	} store_ctrl_t;

	// Status from the key store to the sequencer.
	typedef struct packed {
		logic done;
		logic hit_a;
		logic hit_b;
	} store_stat_t;

endpackage

// ===== design/kmer_set_read_filter_top.sv =====
// Top level of the k-mer set read filter: configuration register and block wiring.
//
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_ready  command, kmer_key, base_code, base_unknown, last_base
// out       output     out_valid/out_ready result_kind, insert_status, read_kept, match_position
// config    input      APB psel/penable   paddr, pwdata, prdata (kmer_length at byte 0)
//
// Membership is a linear scan of the filled table through a single memory read port.
// An insert scans the filled table, then decides and writes up to two keys; a read base
// scans only when its window holds k clean bases and the read has no match yet.
// After reset the table is empty by its fill count; there is no clearing pass.
// in_ready is high only between items; when a result is still waiting, the next one
// holds the sequencer until it can load, and in_ready stays low meanwhile.
module kmer_set_read_filter_top
	import kmsrf_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int MAX_K         = MAX_K_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   command,
	input  logic [KMER_KEY_W-1:0]  kmer_key,
	input  logic [1:0]             base_code,
	input  logic                   base_unknown,
	input  logic                   last_base,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   result_kind,
	output logic [1:0]             insert_status,
	output logic                   read_kept,
	output logic [MATCH_POS_W-1:0] match_position
);

	localparam int KEY_W = 2 * MAX_K;
	localparam int K_W   = $clog2(MAX_K + 1);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	logic [CFG_K_W-1:0] kmer_length_q;
	logic               reg_hit;
	logic [5:0]         kl_ext;
	logic [5:0]         k_clamp;
	logic [K_W-1:0]     k_eff;
	store_ctrl_t        ctrl;
	store_stat_t        stat;
	logic [CNT_W-1:0]   count;
	logic [KEY_W-1:0]   key_a, key_b;

	// Configuration port: always ready, one register.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_KMER_LENGTH);
	assign prdata  = reg_hit ? APB_DATA_W'(kmer_length_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= KMER_LENGTH_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			kmer_length_q <= pwdata[CFG_K_W-1:0];
		end
	end

	// Effective k: zero acts as one, anything above the maximum acts as the maximum.
	always_comb begin
		kl_ext = 6'(kmer_length_q);
		if (kl_ext == 6'd0) begin
			k_clamp = 6'd1;
		end else if (kl_ext > 6'(MAX_K)) begin
			k_clamp = 6'(MAX_K);
		end else begin
			k_clamp = kl_ext;
		end
	end
	assign k_eff = K_W'(k_clamp);

	kmsrf_key_store #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.KEY_W         (KEY_W)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.key_a  (key_a),
		.key_b  (key_b),
		.stat   (stat),
		.count  (count)
	);

	kmsrf_seq #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_K         (MAX_K),
		.POSITION_BITS (POSITION_BITS)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.k_eff          (k_eff),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.kmer_key       (kmer_key),
		.base_code      (base_code),
		.base_unknown   (base_unknown),
		.last_base      (last_base),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.insert_status  (insert_status),
		.read_kept      (read_kept),
		.match_position (match_position),
		.ctrl           (ctrl),
		.stat           (stat),
		.count          (count),
		.key_a          (key_a),
		.key_b          (key_b)
	);

endmodule

// ===== design/kmsrf_key_store.sv =====
// Key table memory with its fill count and the scan comparators for both keys.
module kmsrf_key_store
	import kmsrf_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int KEY_W         = 2 * MAX_K_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  store_ctrl_t                        ctrl,
	input  logic [KEY_W-1:0]                   key_a,
	input  logic [KEY_W-1:0]                   key_b,
	output store_stat_t                        stat,
	output logic [$clog2(TABLE_ENTRIES+1)-1:0] count
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	logic [KEY_W-1:0] mem [TABLE_ENTRIES];
	logic [KEY_W-1:0] rd_data_s1;
	logic             rd_pend_s1;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic             scanning_q;
	logic             hit_a_q;
	logic             hit_b_q;
	logic             issue;
	logic             done;
	logic             wr_en;
	logic [KEY_W-1:0] wr_data;

	// A read is issued for every filled entry; the scan ends once the last one is compared.
	assign issue   = scanning_q && (scan_idx_q < count_q);
	assign done    = scanning_q && !issue && !rd_pend_s1;
	assign wr_en   = ctrl.wr_a || ctrl.wr_b;
	assign wr_data = ctrl.wr_a ? key_a : key_b;

	assign stat.done  = done;
	assign stat.hit_a = hit_a_q;
	assign stat.hit_b = hit_b_q;
	assign count      = count_q;

	// Memory: one write port at the fill count, one registered read port at the scan index.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IDX_W-1:0]] <= wr_data;
		end
		rd_data_s1 <= mem[scan_idx_q[IDX_W-1:0]];
	end

	// Scan sequencing, hit flags and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
			scanning_q <= 1'b0;
			rd_pend_s1 <= 1'b0;
			hit_a_q    <= 1'b0;
			hit_b_q    <= 1'b0;
		end else begin
			if (ctrl.start) begin
				scanning_q <= 1'b1;
				scan_idx_q <= '0;
				rd_pend_s1 <= 1'b0;
				hit_a_q    <= 1'b0;
				hit_b_q    <= 1'b0;
			end else if (scanning_q) begin
				if (issue) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				rd_pend_s1 <= issue;
				if (rd_pend_s1 && (rd_data_s1 == key_a)) begin
					hit_a_q <= 1'b1;
				end
				if (rd_pend_s1 && (rd_data_s1 == key_b)) begin
					hit_b_q <= 1'b1;
				end
				if (done) begin
					scanning_q <= 1'b0;
				end
			end
			if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_dual_write: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_a |-> !ctrl.wr_b)
		else $error("key store: two writes in one cycle");

	a_write_fits: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (count_q < CNT_W'(TABLE_ENTRIES)))
		else $error("key store: write into a full table");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scanning_q |-> !wr_en)
		else $error("key store: write during a scan");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> !scanning_q)
		else $error("key store: scan started while scanning");
`endif

endmodule

// ===== design/kmsrf_seq.sv =====
// Sequencer: insert decisions, the rolling read window and the result register.
module kmsrf_seq
	import kmsrf_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int MAX_K         = MAX_K_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [$clog2(MAX_K+1)-1:0]         k_eff,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               command,
	input  logic [KMER_KEY_W-1:0]              kmer_key,
	input  logic [1:0]                         base_code,
	input  logic                               base_unknown,
	input  logic                               last_base,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               result_kind,
	output logic [1:0]                         insert_status,
	output logic                               read_kept,
	output logic [MATCH_POS_W-1:0]             match_position,
	output store_ctrl_t                        ctrl,
	input  store_stat_t                        stat,
	input  logic [$clog2(TABLE_ENTRIES+1)-1:0] count,
	output logic [2*MAX_K-1:0]                 key_a,
	output logic [2*MAX_K-1:0]                 key_b
);

	localparam int KEY_W = 2 * MAX_K;
	localparam int K_W   = $clog2(MAX_K + 1);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	seq_state_t               state_q, state_d;
	logic [KEY_W-1:0]         key_a_q, key_b_q;
	logic                     palin_q;
	logic [KEY_W-1:0]         window_q;
	logic [K_W-1:0]           run_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     matched_q;
	logic [POSITION_BITS-1:0] first_q;
	logic                     is_ins_q;
	logic                     lookup_q;
	logic                     last_q;
	ins_status_t              status_q, status_d;
	logic                     out_valid_q;
	logic                     kind_q;
	ins_status_t              out_status_q;
	logic                     kept_q;
	logic [MATCH_POS_W-1:0]   mpos_q;

	logic [KEY_W-1:0]         mask;
	logic [KEY_W-1:0]         fw;
	logic [KEY_W-1:0]         fw_rev;
	logic [KEY_W-1:0]         rc;
	logic [KEY_W-1:0]         win_d;
	logic [K_W-1:0]           run_d;
	logic                     lookup_d;
	logic                     has_a, has_b;
	logic [1:0]               need;
	logic [CNT_W:0]           fill_sum;
	logic                     match_now;
	logic                     matched_d;
	logic [POSITION_BITS-1:0] first_calc;
	logic [POSITION_BITS-1:0] first_d;
	logic [POSITION_BITS-1:0] pos_inc;
	logic [31:0]              first_ext;
	logic [MATCH_POS_W-1:0]   first_sat;
	logic                     out_free;
	logic                     take_ins, take_read, status_ld, read_commit, out_ld;
	logic                     out_kind_d;
	ins_status_t              out_status_d;
	logic                     out_kept_d;
	logic [MATCH_POS_W-1:0]   out_pos_d;

	assign key_a = key_a_q;
	assign key_b = key_b_q;

	// Key mask for the current k; a shift past the width leaves all ones.
	assign mask = ~({KEY_W{1'b1}} << (2 * k_eff));
	assign fw   = KEY_W'(kmer_key) & mask;

	// Reverse complement: complement and reverse all base slots, then align to k bases.
	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			fw_rev[2*(MAX_K-1-i) +: 2] = ~fw[2*i +: 2];
		end
	end
	assign rc = (fw_rev >> (2 * (MAX_K - int'(k_eff)))) & mask;

	// Rolling window update for a read base.
	assign win_d    = base_unknown ? '0 : (((window_q << 2) | KEY_W'(base_code)) & mask);
	assign run_d    = base_unknown ? '0 : ((run_q < k_eff) ? run_q + 1'b1 : run_q);
	assign lookup_d = !base_unknown && (run_d >= k_eff) && !matched_q;

	// Insert decision from the scan hits.
	assign has_a    = stat.hit_a;
	assign has_b    = palin_q || stat.hit_b;
	assign need     = {1'b0, !has_a} + {1'b0, !has_b};
	assign fill_sum = (CNT_W+1)'(count) + (CNT_W+1)'(need);

	// Read verdict arithmetic.
	assign match_now  = lookup_q && stat.hit_a;
	assign matched_d  = matched_q || match_now;
	assign first_calc = (pos_q == POS_MAX) ? POS_MAX
		: (pos_q + 1'b1 - POSITION_BITS'(k_eff));
	assign first_d    = match_now ? first_calc : first_q;
	assign pos_inc    = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
	assign first_ext  = 32'(first_d);
	assign first_sat  = (first_ext > 32'd65535) ? '1 : first_ext[MATCH_POS_W-1:0];

	assign out_free = !out_valid_q || out_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes.
	always_comb begin
		state_d     = state_q;
		ctrl        = '0;
		in_ready    = 1'b0;
		take_ins    = 1'b0;
		take_read   = 1'b0;
		status_ld   = 1'b0;
		status_d    = status_q;
		read_commit = 1'b0;
		out_ld      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (command == CMD_INSERT) begin
						take_ins   = 1'b1;
						ctrl.start = 1'b1;
						state_d    = ST_SCAN;
					end else begin
						take_read = 1'b1;
						if (lookup_d) begin
							ctrl.start = 1'b1;
							state_d    = ST_SCAN;
						end else begin
							state_d = ST_READ_DONE;
						end
					end
				end
			end
			ST_SCAN: begin
				if (stat.done) begin
					state_d = is_ins_q ? ST_DECIDE : ST_READ_DONE;
				end
			end
			ST_DECIDE: begin
				status_ld = 1'b1;
				if (need == 2'd0) begin
					status_d = INS_PRESENT;
					state_d  = ST_INS_OUT;
				end else if (fill_sum > (CNT_W+1)'(TABLE_ENTRIES)) begin
					status_d = INS_FULL;
					state_d  = ST_INS_OUT;
				end else begin
					status_d = INS_ADDED;
					if (!has_a) begin
						ctrl.wr_a = 1'b1;
						state_d   = has_b ? ST_INS_OUT : ST_WRITE_B;
					end else begin
						ctrl.wr_b = 1'b1;
						state_d   = ST_INS_OUT;
					end
				end
			end
			ST_WRITE_B: begin
				ctrl.wr_b = 1'b1;
				state_d   = ST_INS_OUT;
			end
			ST_INS_OUT: begin
				if (out_free) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_READ_DONE: begin
				if (!last_q || out_free) begin
					read_commit = 1'b1;
					out_ld      = last_q;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Result values for the output register.
	always_comb begin
		if (is_ins_q) begin
			out_kind_d   = RES_INSERT;
			out_status_d = status_q;
			out_kept_d   = 1'b0;
			out_pos_d    = '0;
		end else begin
			out_kind_d   = RES_READ;
			out_status_d = INS_ADDED;
			out_kept_d   = matched_d;
			out_pos_d    = matched_d ? first_sat : '0;
		end
	end

	// Keys under comparison.
	always_ff @(posedge clk) begin
		if (take_ins) begin
			key_a_q <= fw;
			key_b_q <= rc;
			palin_q <= (fw == rc);
		end else if (take_read) begin
			key_a_q <= win_d;
			key_b_q <= win_d;
			palin_q <= 1'b1;
		end
	end

	// Read state, item flags and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			run_q       <= '0;
			pos_q       <= '0;
			matched_q   <= 1'b0;
			first_q     <= '0;
			is_ins_q    <= 1'b0;
			lookup_q    <= 1'b0;
			last_q      <= 1'b0;
			status_q    <= INS_ADDED;
			out_valid_q <= 1'b0;
		end else begin
			if (take_ins) begin
				is_ins_q <= 1'b1;
			end
			if (take_read) begin
				is_ins_q <= 1'b0;
				window_q <= win_d;
				run_q    <= run_d;
				lookup_q <= lookup_d;
				last_q   <= last_base;
			end
			if (status_ld) begin
				status_q <= status_d;
			end
			if (read_commit) begin
				if (last_q) begin
					window_q  <= '0;
					run_q     <= '0;
					pos_q     <= '0;
					matched_q <= 1'b0;
					first_q   <= '0;
				end else begin
					matched_q <= matched_d;
					first_q   <= first_d;
					pos_q     <= pos_inc;
				end
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (out_ld) begin
			kind_q       <= out_kind_d;
			out_status_q <= out_status_d;
			kept_q       <= out_kept_d;
			mpos_q       <= out_pos_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = kind_q;
	assign insert_status  = out_status_q;
	assign read_kept      = kept_q;
	assign match_position = mpos_q;

`ifndef NO_ASSERTIONS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != ST_IDLE))
		else $error("seq: accepted beat left the sequencer idle");

	a_write_b_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE_B) |-> $past(state_q == ST_DECIDE))
		else $error("seq: second key write not after decision");

	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (state_q == ST_SCAN))
		else $error("seq: scan finished outside the scan state");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench of the k-mer set read filter, with an in-bench predictor.
module testbench;
	import kmsrf_pkg::*;

	localparam int TABLE_N       = TABLE_ENTRIES_DEF;
	localparam int MAX_KLEN      = MAX_K_DEF;
	localparam int POS_MAX       = (1 << POSITION_BITS_DEF) - 1;
	localparam int INSERT_CAP    = 200;
	localparam int RANDOM_ITEMS  = 1100;
	localparam int PHASE_ITEMS   = 70;
	localparam int PAL_K         = 10;
	localparam int SETTLE_EXTRA  = 10;

	typedef logic [KMER_KEY_W-1:0] key_t;

	typedef struct {
		logic       cmd;
		key_t       key;
		logic [1:0] base;
		logic       unk;
		logic       last;
	} item_t;

	typedef struct packed {
		logic                   kind;
		logic [1:0]             status;
		logic                   kept;
		logic [MATCH_POS_W-1:0] position;
	} outcome_t;

	typedef struct {
		bit         cfg;
		logic [4:0] k_value;
		item_t      it;
		bit         typed;
		outcome_t   want;
	} row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_ADDR_W-1:0]  paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;
	logic                   in_valid;
	logic                   in_ready;
	logic                   command;
	key_t                   kmer_key;
	logic [1:0]             base_code;
	logic                   base_unknown;
	logic                   last_base;
	logic                   out_valid;
	logic                   out_ready;
	logic                   result_kind;
	logic [1:0]             insert_status;
	logic                   read_kept;
	logic [MATCH_POS_W-1:0] match_position;

	// Predictor copy of the key set, the register and the per-read state.
	key_t       key_store [TABLE_N];
	int         stored_n = 0;
	logic [4:0] k_reg = KMER_LENGTH_RESET;
	key_t       win = '0;
	int         clean_len = 0;
	int         base_pos = 0;
	bit         hit_seen = 0;
	int         hit_start = 0;

	outcome_t outcome_q[$];
	row_t     dir_rows[$];
	int       fails = 0;
	int       items_sent = 0;
	bit       idle_gaps = 1;

	kmer_set_read_filter_top u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic key_t rand62();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[KMER_KEY_W-1:0];
	endfunction

	// Effective k: zero acts as one, anything above the maximum acts as the maximum.
	function automatic int cur_k();
		int k;
		k = int'(k_reg);
		if (k < 1) k = 1;
		if (k > MAX_KLEN) k = MAX_KLEN;
		return k;
	endfunction

	function automatic key_t k_mask(int k);
		logic [63:0] m;
		m = (64'd1 << (2 * k)) - 64'd1;
		return m[KMER_KEY_W-1:0];
	endfunction

	function automatic key_t rev_comp_key(key_t key, int k);
		key_t rc;
		rc = '0;
		for (int i = 0; i < k; i++) begin
			rc = {rc[KMER_KEY_W-3:0], ~key[2*i +: 2]};
		end
		return rc;
	endfunction

	function automatic bit key_known(key_t key);
		for (int i = 0; i < stored_n; i++) begin
			if (key_store[i] == key) return 1'b1;
		end
		return 1'b0;
	endfunction

	// A k-mer equal to its own reverse complement. Odd k has none, so there the
	// middle base is left random and the key is an ordinary one.
	function automatic key_t palindrome_key(int k);
		key_t p;
		logic [1:0] b;
		p = '0;
		for (int i = 0; i < k / 2; i++) begin
			b = 2'($urandom);
			p[2*(k-1-i) +: 2] = b;
			p[2*i +: 2] = ~b;
		end
		if (k % 2) p[2*(k/2) +: 2] = 2'($urandom);
		return p;
	endfunction

	function automatic void clear_read();
		win = '0;
		clean_len = 0;
		base_pos = 0;
		hit_seen = 0;
		hit_start = 0;
	endfunction

	// Advances the predictor by one accepted beat; returns 1 when a result is due.
	function automatic bit apply_item(input item_t it, output outcome_t res);
		int k;
		int need;
		key_t m;
		key_t fw;
		key_t rc;
		bit has_fw;
		bit has_rc;
		logic [1:0] status;
		k = cur_k();
		m = k_mask(k);
		res = '0;
		if (it.cmd == CMD_INSERT) begin
			fw = it.key & m;
			rc = rev_comp_key(fw, k) & m;
			has_fw = key_known(fw);
			has_rc = (rc == fw) ? 1'b1 : key_known(rc);
			need = int'(!has_fw) + int'(!has_rc);
			if (need == 0) begin
				status = INS_PRESENT;
			end else if (stored_n + need > TABLE_N) begin
				status = INS_FULL;
			end else begin
				if (!has_fw) key_store[stored_n++] = fw;
				if (!has_rc) key_store[stored_n++] = rc;
				status = INS_ADDED;
			end
			res.kind = RES_INSERT;
			res.status = status;
			return 1'b1;
		end
		// An unknown base restarts the window; a clean one shifts in and may look up.
		if (it.unk) begin
			clean_len = 0;
			win = '0;
		end else begin
			win = ((win << 2) | key_t'(it.base)) & m;
			if (clean_len < k) clean_len++;
			if (clean_len >= k && !hit_seen && key_known(win)) begin
				hit_seen = 1'b1;
				hit_start = (base_pos >= POS_MAX) ? POS_MAX : base_pos + 1 - k;
			end
		end
		if (base_pos < POS_MAX) base_pos++;
		if (it.last) begin
			res.kind = RES_READ;
			res.kept = hit_seen;
			res.position = hit_seen ? MATCH_POS_W'(hit_start) : '0;
			clear_read();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void check_field(string fname, logic [15:0] want, logic [15:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, got %0d", fname, want, seen);
			fails++;
		end
	endfunction

	// Result monitor: every beat is matched against the oldest pending outcome.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (outcome_q.size() == 0) begin
				$error("result beat with no outcome pending");
				fails++;
			end else begin
				want = outcome_q.pop_front();
				check_field("result_kind", 16'(want.kind), 16'(result_kind));
				check_field("insert_status", 16'(want.status), 16'(insert_status));
				check_field("read_kept", 16'(want.kept), 16'(read_kept));
				check_field("match_position", want.position, match_position);
			end
		end
	end

	// Result side: a random stall before each beat, unless gaps are off.
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_gaps ? $urandom_range(0, 19) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Drives one input beat after a random gap and records the outcome it causes.
	task automatic push_item(item_t it, bit typed, outcome_t want);
		int gap;
		outcome_t res;
		gap = idle_gaps ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= it.cmd;
		kmer_key <= it.key;
		base_code <= it.base;
		base_unknown <= it.unk;
		last_base <= it.last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (apply_item(it, res)) outcome_q.push_back(typed ? want : res);
	endtask

	// Waits until every outcome has arrived and the last scan has surely ended.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (stored_n + SETTLE_EXTRA) @(posedge clk);
	endtask

	// Writes kmer_length with junk in the upper bits, then reads it back.
	task automatic write_k(logic [4:0] kv);
		logic [31:0] junk;
		settle();
		junk = $urandom;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_KMER_LENGTH, 2'b00};
		pwdata <= {junk[31:5], kv};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		k_reg = kv;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DATA_W'(kv)) begin
			$error("prdata: expected %0d, got %0d", kv, prdata);
			fails++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Inserts a k-mer with random bits above the current key width.
	task automatic send_insert(key_t content);
		item_t it;
		key_t m;
		m = k_mask(cur_k());
		it.cmd = CMD_INSERT;
		it.key = (content & m) | (rand62() & ~m);
		it.base = 2'($urandom);
		it.unk = 1'($urandom);
		it.last = 1'($urandom);
		push_item(it, 1'b0, '0);
	endtask

	task automatic random_insert();
		int pick;
		key_t content;
		pick = $urandom_range(0, 3);
		if (stored_n == 0 || (stored_n < INSERT_CAP && pick < 2)) begin
			content = rand62();
		end else if (stored_n < INSERT_CAP && pick == 2) begin
			content = palindrome_key(cur_k());
		end else begin
			content = key_store[$urandom_range(0, stored_n - 1)];
		end
		send_insert(content);
	endtask

	// One whole read, often carrying a stored k-mer, with sparse unknown bases.
	task automatic random_read();
		int k;
		int len;
		int spot;
		key_t motif;
		logic [1:0] bases[$];
		bit unk_flags[$];
		item_t it;
		k = cur_k();
		if ($urandom_range(0, 4) == 0) len = $urandom_range(1, k);
		else len = $urandom_range(k, k + 8);
		for (int i = 0; i < len; i++) begin
			bases.push_back(2'($urandom));
			unk_flags.push_back($urandom_range(0, 15) == 0);
		end
		if (stored_n > 0 && len >= k && $urandom_range(0, 4) != 0) begin
			motif = key_store[$urandom_range(0, stored_n - 1)];
			spot = $urandom_range(0, len - k);
			for (int i = 0; i < k; i++) begin
				bases[spot+i] = motif[2*(k-1-i) +: 2];
				unk_flags[spot+i] = 1'b0;
			end
		end
		for (int i = 0; i < len; i++) begin
			it.cmd = CMD_READ_BASE;
			it.key = rand62();
			it.base = bases[i];
			it.unk = unk_flags[i];
			it.last = (i == len - 1);
			push_item(it, 1'b0, '0);
		end
	endtask

	task automatic random_phase();
		int r;
		logic [4:0] kv;
		int start;
		r = $urandom_range(0, 9);
		if (r == 0) kv = 5'd0;
		else if (r == 1) kv = 5'd31;
		else if (r < 7) kv = 5'($urandom_range(1, 4));
		else kv = 5'($urandom_range(1, 31));
		write_k(kv);
		idle_gaps = ($urandom_range(0, 3) != 0);
		start = items_sent;
		while (items_sent - start < PHASE_ITEMS) begin
			if ($urandom_range(0, 3) == 0) random_insert();
			else random_read();
		end
	endtask

	function automatic void add_ins(key_t key, bit typed, ins_status_t st);
		row_t r;
		r.cfg = 1'b0;
		r.k_value = '0;
		r.it = '{CMD_INSERT, key, 2'($urandom), 1'($urandom), 1'($urandom)};
		r.typed = typed;
		r.want = '{RES_INSERT, st, 1'b0, '0};
		dir_rows.push_back(r);
	endfunction

	function automatic void add_base(logic [1:0] b, bit unk, bit last, bit typed,
			bit kept, logic [MATCH_POS_W-1:0] pos);
		row_t r;
		r.cfg = 1'b0;
		r.k_value = '0;
		r.it = '{CMD_READ_BASE, rand62(), b, unk, last};
		r.typed = typed;
		r.want = '{RES_READ, 2'b00, kept, pos};
		dir_rows.push_back(r);
	endfunction

	function automatic void add_cfg(logic [4:0] kv);
		row_t r;
		r = '{1'b1, kv, '{CMD_INSERT, '0, '0, 1'b0, 1'b0}, 1'b0, '0};
		dir_rows.push_back(r);
	endfunction

	// Directed rows: reset k, extremes of k, palindromes, inserts inside a read.
	function automatic void load_rows();
		add_ins(62'h3FFF_FFFF_FFFF_FFFF, 1, INS_ADDED);
		add_ins(62'h0, 1, INS_PRESENT);
		add_ins(62'h2AAA_AAAA_AAAA_AAAA, 0, INS_ADDED);
		add_base(2'd3, 0, 1, 1, 0, '0);
		add_cfg(5'd0);
		add_ins(62'h3FFF_FFFF_FFFF_FFFF, 1, INS_ADDED);
		add_base(2'd3, 0, 1, 1, 1, '0);
		add_base(2'd2, 1, 1, 1, 0, '0);
		add_base(2'd1, 0, 0, 0, 0, '0);
		add_base(2'd0, 0, 1, 0, 0, '0);
		add_cfg(5'd2);
		add_ins(62'h3FFF_FFFF_FFFF_FFC3, 0, INS_ADDED);
		add_base(2'd1, 0, 0, 0, 0, '0);
		add_ins(62'h1555_5555_5555_5556, 0, INS_ADDED);
		add_base(2'd2, 0, 1, 0, 0, '0);
		add_base(2'd0, 0, 0, 0, 0, '0);
		add_base(2'd2, 1, 0, 0, 0, '0);
		add_base(2'd3, 0, 0, 0, 0, '0);
		add_base(2'd0, 0, 1, 0, 0, '0);
		add_cfg(5'd31);
		add_ins(62'h0, 1, INS_PRESENT);
		add_base(2'd0, 0, 1, 1, 0, '0);
	endfunction

	initial begin
		int start;
		int tries;
		key_t content;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		command <= CMD_INSERT;
		kmer_key <= '0;
		base_code <= '0;
		base_unknown <= 1'b0;
		last_base <= 1'b0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		load_rows();
		idle_gaps = 1;
		for (int i = 0; i < dir_rows.size(); i++) begin
			if (dir_rows[i].cfg) write_k(dir_rows[i].k_value);
			else push_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		end

		// Random part with a fresh k for every phase.
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) random_phase();

		// Fill the table: make the count odd, then add pairs until one slot is left.
		idle_gaps = 1;
		write_k(5'(PAL_K));
		if (stored_n % 2 == 0) begin
			do content = palindrome_key(PAL_K); while (key_known(content));
			send_insert(content);
		end
		write_k(5'd31);
		tries = 0;
		while (stored_n < TABLE_N - 1 && tries < 2 * TABLE_N) begin
			send_insert(rand62());
			tries++;
		end
		// A pair does not fit into the last slot, a single palindrome does.
		send_insert(rand62());
		write_k(5'(PAL_K));
		do content = palindrome_key(PAL_K); while (key_known(content));
		send_insert(content);
		send_insert(rand62());
		send_insert(content);

		// A few reads against the full table.
		write_k(5'd3);
		repeat (6) random_read();

		settle();
		if (fails == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
